>>> src/modulated_feedback_delay_assert.svh
// Assertion macros shared by the checker of the modulated feedback delay.
`ifndef MODULATED_FEEDBACK_DELAY_ASSERT_SVH
`define MODULATED_FEEDBACK_DELAY_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mfd_pkg.sv
// Package: constants, register indexes and field widths of the modulated feedback delay.
package mfd_pkg;

  localparam int BUFFER_DEPTH_DEF = 65536;
  localparam int SAMPLE_BITS_DEF  = 24;

  localparam int MOD_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int BASE_W  = 32;
  localparam int DEPTH_W = 24;
  localparam int GAIN_W  = 16;
  localparam int MIX_W   = 17;
  localparam int COEF_W  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_COEFF  = 3'd4;

  localparam logic [BASE_W-1:0]  DELAY_BASE_RST    = 32'd0;
  localparam logic [DEPTH_W-1:0] MOD_DEPTH_RST     = 24'd6291456;
  localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST = 16'd0;
  localparam logic [MIX_W-1:0]   WET_MIX_RST       = 17'd0;
  localparam logic [COEF_W-1:0]  SMOOTH_COEFF_RST  = 16'd131;

  // Unity in Q1.16
  localparam logic [MIX_W-1:0] Q16_ONE = 17'h10000;

endpackage

>>> src/mfd_if.sv
// Channel interfaces: input samples, output samples and register writes.
interface mfd_in_if #(
  parameter int SAMPLE_BITS = mfd_pkg::SAMPLE_BITS_DEF
);
  import mfd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_in;
  logic signed [MOD_W-1:0]       mod_in;

  modport source (output valid, output audio_in, output mod_in, input ready);
  modport sink   (input valid, input audio_in, input mod_in, output ready);
endinterface

interface mfd_out_if #(
  parameter int SAMPLE_BITS = mfd_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink   (input valid, input audio_out, output ready);
endinterface

interface mfd_cfg_if;
  import mfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/mfd_store.sv
// Sample store: one write port, two read ports with registered read data.
module mfd_store #(
  parameter int BUFFER_DEPTH = mfd_pkg::BUFFER_DEPTH_DEF,
  parameter int SAMPLE_BITS  = mfd_pkg::SAMPLE_BITS_DEF,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd0_addr,
  input  logic [AW-1:0]                 rd1_addr,
  output logic signed [SAMPLE_BITS-1:0] rd0_data,
  output logic signed [SAMPLE_BITS-1:0] rd1_data
);
  import mfd_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd0_data_r;
  logic signed [SAMPLE_BITS-1:0] rd1_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd0_data_r <= mem[rd0_addr];
      rd1_data_r <= mem[rd1_addr];
    end
  end

  assign rd0_data = rd0_data_r;
  assign rd1_data = rd1_data_r;

endmodule

>>> src/modulated_feedback_delay.sv
// Modulated fractional feedback delay line with linear interpolation, top level.
// Each input item (audio_in, mod_in) yields one audio_out item. The target delay
// delay_base + mod_depth*mod_in is smoothed by a one-pole filter, clamped to
// 1..BUFFER_DEPTH-2 samples, and the store is read at two neighboring entries
// behind the write pointer and interpolated by the fraction. The input plus
// feedback_gain times the previous tap is written back saturated, and the output
// is the wet/dry mix. Each item passes through the states MUL1, TGT, MUL2, SM,
// ADDR, RD, TAP, MIX and OUT before the next item can be accepted, with the result
// registered in OUT; the sequence comes from the chain of dependent multiplies
// (modulation, smoothing, interpolation, mix) and the registered read of the
// sample store. The output register lets a new item in while a result waits;
// a second result stalls in the last stage until the first is taken. Entries not
// yet written since reset read as zero through the write pointer and a wrap flag,
// so there is no clearing pass after reset. Register writes are taken at any time
// (cfg_ch.ready is always high) but should only be made while the block is idle.
module modulated_feedback_delay #(
  parameter int BUFFER_DEPTH = mfd_pkg::BUFFER_DEPTH_DEF,
  parameter int SAMPLE_BITS  = mfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mfd_in_if.sink      in_ch,
  mfd_out_if.source   out_ch,
  mfd_cfg_if.sink     cfg_ch
);
  import mfd_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = AW + 33;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL1 = 4'd1;
  localparam logic [3:0] ST_TGT  = 4'd2;
  localparam logic [3:0] ST_MUL2 = 4'd3;
  localparam logic [3:0] ST_SM   = 4'd4;
  localparam logic [3:0] ST_ADDR = 4'd5;
  localparam logic [3:0] ST_RD   = 4'd6;
  localparam logic [3:0] ST_TAP  = 4'd7;
  localparam logic [3:0] ST_MIX  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam logic [CW-1:0] D_MIN = CW'(1) << FRAC_W;
  localparam logic [CW-1:0] D_MAX = CW'(BUFFER_DEPTH - 2) << FRAC_W;
  localparam logic [CW-1:0] SPAN  = CW'(BUFFER_DEPTH) << FRAC_W;
  localparam logic [AW-1:0] LAST_POS = AW'(BUFFER_DEPTH - 1);

  localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};

  // configuration
  logic [BASE_W-1:0]  delay_base_r;
  logic [DEPTH_W-1:0] mod_depth_r;
  logic [GAIN_W-1:0]  feedback_gain_r;
  logic [MIX_W-1:0]   wet_mix_r;
  logic [COEF_W-1:0]  smooth_coeff_r;

  // control and persistent state
  logic [3:0]           state_r, state_nxt;
  logic [AW-1:0]        wp_r;
  logic                 wrapped_r;
  logic [31:0]          sm_r;
  logic signed [SB-1:0] last_tap_r;
  logic                 out_valid_r;

  // per-item payload registers
  logic signed [SB-1:0]        x_r;
  logic signed [MOD_W-1:0]     m_r;
  logic signed [DEPTH_W+16:0]  prod1_r;
  logic signed [32:0]          diff_r;
  logic signed [49:0]          prod2_r;
  logic [FRAC_W-1:0]           t_r;
  logic                        v0_r, v1_r;
  logic signed [SB+16:0]       fbprod_r;
  logic signed [SB-1:0]        y0_r;
  logic signed [SB+17:0]       prodt_r;
  logic signed [SB-1:0]        tap_r;
  logic signed [SB-1:0]        wdata_r;
  logic signed [SB+17:0]       pm1_r, pm2_r;
  logic signed [SB-1:0]        out_data_r;

  // combinational
  logic                  in_fire, out_free;
  logic signed [33:0]    tgt_sum;
  logic [31:0]           target;
  logic signed [32:0]    diff_nxt;
  logic signed [34:0]    sm_sum;
  logic [31:0]           sm_nxt;
  logic [CW-1:0]         d_clamp, rp_raw, rp;
  logic [AW-1:0]         i0, i1;
  logic signed [SB-1:0]  rd0_data, rd1_data, y0, y1;
  logic signed [SB:0]    dy;
  logic signed [SB+1:0]  tap_sum, w_sum;
  logic signed [SB-1:0]  wdata_nxt;
  logic [MIX_W-1:0]      wet, dry;
  logic signed [SB+18:0] mix_sum;
  logic signed [SB+2:0]  mix_scaled;
  logic signed [SB-1:0]  out_nxt;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.audio_out = out_data_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_TGT;
      ST_TGT:  state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SM;
      ST_SM:   state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_TAP;
      ST_TAP:  state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // target delay, clamped to 32 bits unsigned
  always_comb begin
    tgt_sum = $signed({2'b00, delay_base_r}) + $signed(34'(prod1_r >>> 15));
    if (tgt_sum[33]) begin
      target = '0;
    end else if (tgt_sum[32]) begin
      target = '1;
    end else begin
      target = tgt_sum[31:0];
    end
    diff_nxt = $signed({1'b0, sm_r}) - $signed({1'b0, target});
  end

  // one-pole smoothing step
  always_comb begin
    sm_sum = $signed({3'b000, sm_r}) - $signed(35'(prod2_r >>> FRAC_W));
    if (sm_sum[34]) begin
      sm_nxt = '0;
    end else if (sm_sum[33:32] != 2'b00) begin
      sm_nxt = '1;
    end else begin
      sm_nxt = sm_sum[31:0];
    end
  end

  // read position behind the write pointer
  always_comb begin
    d_clamp = CW'(sm_r);
    if (d_clamp < D_MIN) d_clamp = D_MIN;
    if (d_clamp > D_MAX) d_clamp = D_MAX;
    rp_raw = ((CW'(wp_r) + CW'(BUFFER_DEPTH)) << FRAC_W) - d_clamp;
    rp     = (rp_raw >= SPAN) ? rp_raw - SPAN : rp_raw;
    i1     = rp[AW+FRAC_W-1:FRAC_W];
    i0     = (i1 == '0) ? LAST_POS : i1 - AW'(1);
  end

  // interpolation and feedback
  always_comb begin
    y0 = v0_r ? rd0_data : '0;
    y1 = v1_r ? rd1_data : '0;
    dy = $signed({y1[SB-1], y1}) - $signed({y0[SB-1], y0});
    tap_sum = $signed({{2{y0_r[SB-1]}}, y0_r}) + $signed((SB+2)'(prodt_r >>> FRAC_W));
    w_sum   = $signed({{2{x_r[SB-1]}}, x_r}) + $signed((SB+2)'(fbprod_r >>> FRAC_W));
    if (&w_sum[SB+1:SB-1] || ~|w_sum[SB+1:SB-1]) begin
      wdata_nxt = w_sum[SB-1:0];
    end else begin
      wdata_nxt = w_sum[SB+1] ? SMP_MIN : SMP_MAX;
    end
  end

  // wet/dry mix
  always_comb begin
    wet = (wet_mix_r > Q16_ONE) ? Q16_ONE : wet_mix_r;
    dry = Q16_ONE - wet;
    mix_sum = $signed({pm1_r[SB+17], pm1_r}) + $signed({pm2_r[SB+17], pm2_r});
    mix_scaled = $signed((SB+3)'(mix_sum >>> FRAC_W));
    if (&mix_scaled[SB+2:SB-1] || ~|mix_scaled[SB+2:SB-1]) begin
      out_nxt = mix_scaled[SB-1:0];
    end else begin
      out_nxt = mix_scaled[SB+2] ? SMP_MIN : SMP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_base_r    <= DELAY_BASE_RST;
      mod_depth_r     <= MOD_DEPTH_RST;
      feedback_gain_r <= FEEDBACK_GAIN_RST;
      wet_mix_r       <= WET_MIX_RST;
      smooth_coeff_r  <= SMOOTH_COEFF_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DELAY_BASE:    delay_base_r    <= cfg_ch.data[BASE_W-1:0];
        REG_MOD_DEPTH:     mod_depth_r     <= cfg_ch.data[DEPTH_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_ch.data[GAIN_W-1:0];
        REG_WET_MIX:       wet_mix_r       <= cfg_ch.data[MIX_W-1:0];
        REG_SMOOTH_COEFF:  smooth_coeff_r  <= cfg_ch.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      sm_r        <= '0;
      last_tap_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SM) sm_r <= sm_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
        last_tap_r  <= tap_r;
        if (wp_r == LAST_POS) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_fire) begin
        x_r <= in_ch.audio_in;
        m_r <= in_ch.mod_in;
      end
      ST_MUL1: prod1_r <= $signed({1'b0, mod_depth_r}) * m_r;
      ST_TGT:  diff_r  <= diff_nxt;
      ST_MUL2: prod2_r <= diff_r * $signed({1'b0, smooth_coeff_r});
      ST_ADDR: begin
        t_r      <= rp[FRAC_W-1:0];
        v0_r     <= wrapped_r || (i0 < wp_r);
        v1_r     <= wrapped_r || (i1 < wp_r);
        fbprod_r <= last_tap_r * $signed({1'b0, feedback_gain_r});
      end
      ST_RD: begin
        y0_r    <= y0;
        prodt_r <= $signed({1'b0, t_r}) * dy;
      end
      ST_TAP: begin
        tap_r   <= tap_sum[SB-1:0];
        wdata_r <= wdata_nxt;
      end
      ST_MIX: begin
        pm1_r <= x_r * $signed({1'b0, dry});
        pm2_r <= tap_r * $signed({1'b0, wet});
      end
      ST_OUT: if (out_free) out_data_r <= out_nxt;
      default: ;
    endcase
  end

  mfd_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .AW           (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (state_r == ST_OUT && out_free),
    .wr_addr  (wp_r),
    .wr_data  (wdata_r),
    .rd_en    (state_r == ST_ADDR),
    .rd0_addr (i0),
    .rd1_addr (i1),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data)
  );

endmodule

>>> src/mfd_checker.sv
// Port-level checker for the modulated feedback delay, bound to the top level.
`include "modulated_feedback_delay_assert.svh"

module mfd_checker (
  input logic       clk,
  input logic       rst_n,
  mfd_in_if.sink    in_ch,
  mfd_out_if.source out_ch
);
  import mfd_pkg::*;

  // a stalled result holds
  `MFD_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.audio_out), "result changed while stalled")

  // one item at a time: input closes right after an item is taken
  `MFD_ASSERT_NXT(a_in_closes, in_ch.valid && in_ch.ready, !in_ch.ready, "input still open after accept")

  // no result can be produced in the cycle right after an item is taken
  `MFD_ASSERT_NXT(a_no_early_result, in_ch.valid && in_ch.ready, !$rose(out_ch.valid), "result too early after accept")

  // a new result only comes from the final stage, while input is closed
  `MFD_ASSERT_IMP(a_result_origin, $rose(out_ch.valid), $past(!in_ch.ready), "result without busy datapath")

endmodule

bind modulated_feedback_delay mfd_checker u_mfd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
